// File: hdl/slcg_pkg.sv
// slcg_pkg: constants and types for the sinc low-pass coefficient generator.
// Used by the sine and divider units, the top level and the testbench.
`timescale 1ns / 1ps
package slcg_pkg;
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598668;
  localparam logic [31:0] SIN_C5 = 32'd85569305;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C9 = 32'd172273;
  localparam logic [29:0] INV_PI_Q30 = 30'd341782638;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] ADDR_TAP_COUNT = 3'd0;
  localparam logic [CFG_AW-1:0] ADDR_CUTOFF = 3'd4;

  typedef struct packed {
    logic [7:0] tap_index;
  } in_item_t;

  typedef struct packed {
    logic signed [17:0] coefficient;
    logic               index_valid;
  } out_item_t;

  // side info carried along the sine pipeline
  typedef struct packed {
    logic        valid_idx;
    logic        centre;
    logic        neg;
    logic [12:0] dmag;
    logic [16:0] centre_val;
  } side_t;
endpackage

// File: hdl/slcg_if.sv
// slcg_if: valid/ready channel carrying one item payload.
// Depends on nothing; payload width is a parameter.
`timescale 1ns / 1ps
interface slcg_if #(parameter int W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/slcg_sine.sv
// slcg_sine: pipelined quarter-wave polynomial sine, Q30 out, with side data.
// Depends on slcg_pkg. The pipeline advances when en is high.
`timescale 1ns / 1ps
module slcg_sine
  import slcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [15:0] x,
  input  side_t       side_in,
  output logic        out_vld,
  output logic [30:0] smag,
  output side_t       side_out
);
  localparam int NS = 7;
  logic [NS-1:0] vld_r;
  side_t         side_r [NS];
  logic [30:0]   u_r [NS];
  logic [31:0]   u2_r [NS];
  logic [31:0]   t_r [NS];

  logic [61:0] uu;
  logic [63:0] m1, m2, m3, m4, m5;
  assign uu = u_r[0] * u_r[0];
  assign m1 = u2_r[1] * SIN_C9;
  assign m2 = u2_r[2] * t_r[2];
  assign m3 = u2_r[3] * t_r[3];
  assign m4 = u2_r[4] * t_r[4];
  assign m5 = {33'd0, u_r[5]} * {32'd0, t_r[5]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0] <= {x, 15'd0};
      side_r[0] <= side_in;
      for (int k = 1; k < NS; k++) begin
        u_r[k] <= u_r[k-1];
        side_r[k] <= side_r[k-1];
      end
      for (int k = 2; k < NS; k++) begin
        u2_r[k] <= u2_r[k-1];
      end
      u2_r[1] <= uu[61:30];
      t_r[2] <= SIN_C7 - m1[61:30];
      t_r[3] <= SIN_C5 - m2[61:30];
      t_r[4] <= SIN_C3 - m3[61:30];
      t_r[5] <= SIN_C1 - m4[61:30];
      t_r[6] <= (m5[61:30] > {1'b0, ONE_Q30}) ? {1'b0, ONE_Q30} : m5[61:30];
    end
  end

  assign out_vld = vld_r[NS-1];
  assign smag = t_r[NS-1][30:0];
  assign side_out = side_r[NS-1];
endmodule

// File: hdl/slcg_div.sv
// slcg_div: pipelined restoring divider, one quotient bit per stage.
// Depends on slcg_pkg. Computes floor(num / (dmag<<43)); 18 stages.
`timescale 1ns / 1ps
module slcg_div
  import slcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [60:0] num,
  input  side_t       side_in,
  output logic        out_vld,
  output logic [17:0] quo,
  output side_t       side_out
);
  // quotient fits 18 bits; bit b of quotient tested against dmag<<(43+b)
  localparam int QB = 18;
  logic [QB-1:0] vld_r;
  side_t         side_r [QB];
  logic [60:0]   rem_r [QB];
  logic [QB-1:0] q_r [QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QB-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    logic [74:0] sub;
    logic [74:0] dsh;
    logic [QB-1:0] qn;
    if (en) begin
      for (int k = 0; k < QB; k++) begin
        dsh = {62'd0, (k == 0 ? side_in.dmag : side_r[k-1].dmag)} << (43 + QB - 1 - k);
        if (k == 0) begin
          sub = {14'd0, num};
          qn = '0;
        end else begin
          sub = {14'd0, rem_r[k-1]};
          qn = q_r[k-1];
        end
        if (sub >= dsh) begin
          rem_r[k] <= 61'(sub - dsh);
          qn[QB-1-k] = 1'b1;
        end else begin
          rem_r[k] <= sub[60:0];
        end
        q_r[k] <= qn;
        side_r[k] <= (k == 0) ? side_in : side_r[k-1];
      end
    end
  end

  assign out_vld = vld_r[QB-1];
  assign quo = q_r[QB-1];
  assign side_out = side_r[QB-1];
endmodule

// File: hdl/sinc_lowpass_coefficient_generator.sv
// sinc_lowpass_coefficient_generator: top level, APB config, phase and output.
// Depends on slcg_pkg, slcg_if, slcg_sine and slcg_div.
//
//  port group | dir | payload
//  in_        | in  | tap_index[7:0]
//  out_       | out | coefficient[17:0] signed, index_valid
//  cfg_       | in  | APB: tap_count @0x0, cutoff_frac @0x4
//
// One item per cycle while the output register is empty or taken; stages: phase, sine, product, divide, out.
// All stages advance together when the output register is empty or taken.
// Reset clears valid bits and sets tap_count=1, cutoff_frac=0.
`timescale 1ns / 1ps
module sinc_lowpass_coefficient_generator
  import slcg_pkg::*;
#(
  parameter int MAX_TAPS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  slcg_if.sink              in_ch,
  slcg_if.source            out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  logic [8:0]  tap_count_r;
  logic [15:0] cutoff_r;
  logic        en;
  in_item_t    in_item;
  out_item_t   out_item_r;
  logic        out_vld_r;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= 9'd1;
      cutoff_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        ADDR_TAP_COUNT: tap_count_r <= cfg_pwdata[8:0];
        ADDR_CUTOFF:    cutoff_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr)
      ADDR_TAP_COUNT: cfg_prdata = {23'd0, tap_count_r};
      ADDR_CUTOFF:    cfg_prdata = {16'd0, cutoff_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;
  assign in_item = in_item_t'(in_ch.data);

  // stage A: offset d = 2i-(N-1)
  logic [12:0] ntap;
  assign ntap = (13'(tap_count_r) > 13'(MAX_TAPS)) ? 13'(MAX_TAPS) : 13'(tap_count_r);
  logic        a_vld_r;
  logic signed [13:0] a_d_r;
  logic        a_ok_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_ok_r <= 13'(in_item.tap_index) < ntap;
      a_d_r <= $signed({5'd0, in_item.tap_index, 1'b0}) - $signed({1'b0, ntap}) + 14'sd1;
    end
  end

  // stage B: phase and quadrant fold; d sign-extended so the phase wraps mod 2^17
  logic [16:0] ph;
  assign ph = 17'(cutoff_r * {{3{a_d_r[13]}}, a_d_r});
  logic        b_vld_r;
  logic [15:0] b_x_r;
  side_t       b_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (en) b_vld_r <= a_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_x_r <= ph[15] ? (16'h8000 - {1'b0, ph[14:0]}) : {1'b0, ph[14:0]};
      b_side_r.valid_idx <= a_ok_r;
      b_side_r.centre <= (a_d_r == 14'sd0);
      b_side_r.neg <= ph[16] ^ a_d_r[13];
      b_side_r.dmag <= a_d_r[13] ? 13'(-a_d_r) : a_d_r[12:0];
      b_side_r.centre_val <= {cutoff_r, 1'b0};
    end
  end

  logic        s_vld;
  logic [30:0] s_mag;
  side_t       s_side;
  slcg_sine u_sine (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(b_vld_r), .x(b_x_r),
    .side_in(b_side_r), .out_vld(s_vld), .smag(s_mag), .side_out(s_side)
  );

  // stages C, D: numerator = smag*INV_PI + (dmag<<42)
  logic        c_vld_r, d_vld_r;
  logic [60:0] c_p_r, d_num_r;
  side_t       c_side_r, d_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= s_vld;
      d_vld_r <= c_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_p_r <= s_mag * INV_PI_Q30;
      c_side_r <= s_side;
      d_num_r <= c_p_r + ({48'd0, c_side_r.dmag} << 42);
      d_side_r <= c_side_r;
    end
  end

  logic        q_vld;
  logic [17:0] q_mag;
  side_t       q_side;
  slcg_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(d_vld_r), .num(d_num_r),
    .side_in(d_side_r), .out_vld(q_vld), .quo(q_mag), .side_out(q_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= q_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r.index_valid <= q_side.valid_idx;
      if (!q_side.valid_idx) out_item_r.coefficient <= '0;
      else if (q_side.centre) out_item_r.coefficient <= $signed({1'b0, q_side.centre_val});
      else if (q_side.neg) out_item_r.coefficient <= -$signed(q_mag);
      else out_item_r.coefficient <= $signed(q_mag);
    end
  end
  assign out_ch.valid = out_vld_r;
  assign out_ch.data = out_item_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_item_r))
    else $error("result changed under stall");
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_item_r.index_valid |-> out_item_r.coefficient == '0)
    else $error("invalid index with nonzero coefficient");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input stalled with empty output");
endmodule

// File: test/sinc_lowpass_coefficient_generator_test.sv
// Testbench for the sinc low-pass coefficient generator: directed and random tap
// indexes over several tap-count/cutoff settings, checked against a local predictor.
// Depends on slcg_pkg, slcg_if and the top level.
`timescale 1ns / 1ps
module sinc_lowpass_coefficient_generator_test
  import slcg_pkg::*;
();

  localparam int LATENCY = 30;
  localparam int MAX_TAPS = 256;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  slcg_if #(.W($bits(in_item_t))) in_ch (clk);
  slcg_if #(.W($bits(out_item_t))) out_ch (clk);

  sinc_lowpass_coefficient_generator #(.MAX_TAPS(MAX_TAPS)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor copy of the registers
  logic [8:0] tap_count_q;
  logic [15:0] cutoff_q;

  out_item_t coef_expected[$];
  int errors;
  int items_sent;
  int coefs_checked;
  int invalid_seen;
  bit hold_off;
  bit gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  // Q30 quarter-wave sine magnitude, x in 0..2^15
  function automatic logic [63:0] quarter_sine_mag(input logic [15:0] x);
    logic [63:0] u, u2, t;
    u = 64'(x) << 15;
    u2 = (u * u) >> 30;
    t = 64'(SIN_C7) - ((u2 * 64'(SIN_C9)) >> 30);
    t = 64'(SIN_C5) - ((u2 * t) >> 30);
    t = 64'(SIN_C3) - ((u2 * t) >> 30);
    t = 64'(SIN_C1) - ((u2 * t) >> 30);
    t = (u * t) >> 30;
    if (t > 64'(ONE_Q30)) t = 64'(ONE_Q30);
    return t;
  endfunction

  function automatic out_item_t sinc_coef(input logic [7:0] idx);
    out_item_t r;
    int unsigned n;
    int d;
    logic [16:0] p;
    logic [1:0] quad;
    logic [15:0] x;
    logic [63:0] smag, dmag, den, mag;
    logic [17:0] c;
    n = (tap_count_q > MAX_TAPS) ? MAX_TAPS : tap_count_q;
    c = '0;
    r.index_valid = 1'b0;
    if (idx < n) begin
      r.index_valid = 1'b1;
      d = 2 * int'(idx) - (int'(n) - 1);
      if (d == 0) begin
        c = 18'(2 * int'(cutoff_q));
      end else begin
        p = 17'(64'(cutoff_q) * 64'(32'(d)));
        quad = p[16:15];
        x = quad[0] ? (16'h8000 - 16'(p[14:0])) : 16'(p[14:0]);
        smag = quarter_sine_mag(x);
        dmag = (d < 0) ? 64'(-d) : 64'(d);
        den = dmag << 43;
        mag = (smag * 64'(INV_PI_Q30) + (den >> 1)) / den;
        c = ((quad >= 2) != (d < 0)) ? -18'(mag) : 18'(mag);
      end
    end
    r.coefficient = c;
    return r;
  endfunction

  task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == ADDR_TAP_COUNT) tap_count_q = data[8:0];
    else if (addr == ADDR_CUTOFF) cutoff_q = data[15:0];
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (coef_expected.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_filter(input int taps, input int cutoff);
    wait_drained();
    apb_write(ADDR_TAP_COUNT, 32'(taps));
    apb_write(ADDR_CUTOFF, 32'(cutoff));
  endtask

  // sends one item; random gap before it when gaps are enabled
  task automatic send_index(input logic [7:0] idx);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    coef_expected.push_back(sinc_coef(idx));
    items_sent++;
  endtask

  // receiver stall pattern plus optional long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else case ($urandom_range(0, 3))
        0: out_ch.ready <= 1'b0;
        default: out_ch.ready <= 1'b1;
      endcase
    end
  end

  // result checker
  initial begin
    out_item_t got, want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (coef_expected.size() == 0) begin
          $error("unexpected item: coefficient %0d index_valid %0b",
                 got.coefficient, got.index_valid);
          errors++;
        end else begin
          want = coef_expected.pop_front();
          coefs_checked++;
          if (!got.index_valid) invalid_seen++;
          if (got.coefficient !== want.coefficient) begin
            $error("coefficient: expected %0d, actual %0d",
                   want.coefficient, got.coefficient);
            errors++;
          end
          if (got.index_valid !== want.index_valid) begin
            $error("index_valid: expected %0b, actual %0b",
                   want.index_valid, got.index_valid);
            errors++;
          end
        end
      end
    end
  end

  task automatic test_reset_defaults();
    // tap count 1, cutoff 0: index 0 is the centre, the rest invalid
    send_index(8'd0);
    send_index(8'd1);
    send_index(8'd255);
  endtask

  task automatic test_directed();
    set_filter(255, 32768);
    send_index(8'd127);
    send_index(8'd0);
    send_index(8'd254);
    send_index(8'd255);
    send_index(8'd126);
    set_filter(256, 32768);
    send_index(8'd0);
    send_index(8'd255);
    send_index(8'd128);
    set_filter(0, 1000);
    send_index(8'd0);
    send_index(8'd200);
    // above MAX_TAPS clamps; cutoff above one half wraps the phase
    set_filter(511, 65535);
    send_index(8'd0);
    send_index(8'd255);
    send_index(8'd100);
    set_filter(33, 16384);
    send_index(8'd16);
    send_index(8'd15);
    send_index(8'd17);
    send_index(8'd32);
    send_index(8'd33);
    set_filter(2, 0);
    send_index(8'd0);
    send_index(8'd1);
  endtask

  task automatic test_random();
    int taps, cutoff;
    gaps_on = 1'b1;
    for (int ph = 0; ph < 10; ph++) begin
      taps = (ph % 3 == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
      cutoff = (ph % 4 == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 32768);
      set_filter(taps, cutoff);
      for (int k = 0; k < 100; k++)
        send_index((taps > 1 && $urandom_range(0, 9) != 0) ?
                   8'($urandom_range(0, (taps > 256 ? 256 : taps) - 1)) :
                   8'($urandom));
    end
  endtask

  task automatic test_backpressure();
    set_filter(101, 9000);
    gaps_on = 1'b0;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 100; k++) send_index(8'($urandom_range(0, 120)));
    join
    gaps_on = 1'b1;
  endtask

  initial begin
    errors = 0; items_sent = 0; coefs_checked = 0; invalid_seen = 0;
    hold_off = 1'b0; gaps_on = 1'b0;
    tap_count_q = 9'd1; cutoff_q = 16'd0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random();
    test_backpressure();
    wait_drained();
    $display("covered %0d tap indexes, %0d results checked (%0d invalid),",
             items_sent, coefs_checked, invalid_seen);
    $display("over tap counts 0..511, cutoffs up to full scale and a long output stall");
    if (errors == 0 && coef_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      if (coef_expected.size() != 0)
        $error("%0d expected items never arrived", coef_expected.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/slcg_pkg.sv
hdl/slcg_if.sv
hdl/slcg_sine.sv
hdl/slcg_div.sv
hdl/sinc_lowpass_coefficient_generator.sv
test/sinc_lowpass_coefficient_generator_test.sv
